FILE: rtl/rtd_pkg.sv
// Shared types and codes for the ring termination detector.
package rtd_pkg;

    localparam int GEN_WIDTH  = 16;
    localparam int NODE_W     = 3;
    localparam int TASK_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [1:0] OP_TASK = 2'd0;
    localparam logic [1:0] OP_MSG  = 2'd1;
    localparam logic [1:0] OP_IDLE = 2'd2;

    localparam logic [2:0] TO_FIRST_SKIP = 3'd2;
    localparam logic [2:0] TO_HIT        = 3'd3;
    localparam logic [2:0] TO_FIRST_HIT  = 3'd4;

    localparam logic [2:0] MK_SHOOT  = 3'd0;
    localparam logic [2:0] MK_WAIT1  = 3'd1;
    localparam logic [2:0] MK_DCHECK = 3'd2;
    localparam logic [2:0] MK_WAIT2  = 3'd3;
    localparam logic [2:0] MK_TERM   = 3'd4;
    localparam logic [2:0] MK_RESET  = 3'd5;

    localparam logic [2:0] PH_NORMAL = 3'd0;
    localparam logic [2:0] PH_SHOOT  = 3'd1;
    localparam logic [2:0] PH_WAIT1  = 3'd2;
    localparam logic [2:0] PH_DCHECK = 3'd3;
    localparam logic [2:0] PH_WAIT2  = 3'd4;
    localparam logic [2:0] PH_POLL   = 3'd5;

    localparam logic [1:0] FD_KEEP    = 2'd0;
    localparam logic [1:0] FD_ENABLE  = 2'd1;
    localparam logic [1:0] FD_DISABLE = 2'd2;

    localparam logic [1:0] EFD_KEEP  = 2'd0;
    localparam logic [1:0] EFD_START = 2'd1;
    localparam logic [1:0] EFD_STOP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TASK_COUNT = 2'd1;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [2:0]        task_outcome;
        logic [2:0]        msg_kind;
        logic [NODE_W-1:0] msg_origin;
        logic              fd_map_empty;
        logic              poll_ready;
    } item_t;

    typedef struct packed {
        logic [2:0]           phase;
        logic [GEN_WIDTH-1:0] gen_count;
        logic [TASK_W-1:0]    idle_points;
        logic                 halted;
    } node_state_t;

    typedef struct packed {
        logic                 send_valid;
        logic [2:0]           send_kind;
        logic [NODE_W-1:0]    send_origin;
        logic [1:0]           fd_tracking;
        logic [1:0]           eventfd_mode;
        logic                 sleep_request;
        logic                 finished;
        logic [GEN_WIDTH-1:0] generation;
        logic [2:0]           node_state;
    } result_t;

endpackage

FILE: rtl/rtd_step.sv
// Next-state and result logic for one item of the termination detector node.
module rtd_step import rtd_pkg::*; (
    input  item_t             item,
    input  logic [NODE_W-1:0] node_id,
    input  logic [TASK_W-1:0] task_count,
    input  node_state_t       cur,
    output node_state_t       nxt,
    output result_t           res
);

    logic own;
    logic newgen;
    logic inc;
    logic bnorm;
    logic full;

    assign own  = (item.msg_origin == node_id);
    assign full = (cur.idle_points == task_count);

    always_comb begin
        nxt    = cur;
        res    = '0;
        newgen = 1'b0;
        inc    = 1'b0;
        bnorm  = 1'b0;
        if (cur.halted) begin
            res.finished = 1'b1;
        end else begin
            case (item.opcode)
                OP_TASK: begin
                    if (cur.phase == PH_NORMAL) begin
                        if (item.task_outcome == TO_FIRST_SKIP) begin
                            inc = 1'b1;
                        end else if (item.task_outcome == TO_FIRST_HIT &&
                                     cur.idle_points != '0) begin
                            nxt.idle_points = cur.idle_points - 1'b1;
                        end
                    end else if (cur.phase inside {PH_SHOOT, PH_DCHECK}) begin
                        if (item.task_outcome == TO_FIRST_SKIP) begin
                            inc = 1'b1;
                        end else if (item.task_outcome inside {TO_HIT, TO_FIRST_HIT}) begin
                            bnorm = 1'b1;
                        end
                    end
                end
                OP_MSG: begin
                    case (item.msg_kind)
                        MK_SHOOT: begin
                            if (!own && cur.phase == PH_NORMAL) begin
                                nxt.phase       = PH_SHOOT;
                                newgen          = 1'b1;
                                res.send_valid  = 1'b1;
                                res.send_kind   = item.msg_kind;
                                res.send_origin = item.msg_origin;
                            end
                        end
                        MK_WAIT1: begin
                            if (cur.phase == PH_WAIT1) begin
                                res.send_valid = 1'b1;
                                if (!own) begin
                                    res.send_kind   = item.msg_kind;
                                    res.send_origin = item.msg_origin;
                                end else begin
                                    nxt.phase       = PH_DCHECK;
                                    res.fd_tracking = FD_ENABLE;
                                    newgen          = 1'b1;
                                    res.send_kind   = MK_DCHECK;
                                    res.send_origin = node_id;
                                end
                            end
                        end
                        MK_DCHECK: begin
                            if (!own && cur.phase == PH_WAIT1) begin
                                nxt.phase       = PH_DCHECK;
                                res.fd_tracking = FD_ENABLE;
                                newgen          = 1'b1;
                                res.send_valid  = 1'b1;
                                res.send_kind   = item.msg_kind;
                                res.send_origin = item.msg_origin;
                            end
                        end
                        MK_WAIT2: begin
                            if (cur.phase == PH_WAIT2) begin
                                res.send_valid = 1'b1;
                                if (!own) begin
                                    res.send_kind   = item.msg_kind;
                                    res.send_origin = item.msg_origin;
                                end else begin
                                    res.send_kind   = MK_TERM;
                                    res.send_origin = node_id;
                                    nxt.halted      = 1'b1;
                                    res.finished    = 1'b1;
                                end
                            end
                        end
                        MK_TERM: begin
                            if (cur.phase == PH_WAIT2) begin
                                res.send_valid  = 1'b1;
                                res.send_kind   = item.msg_kind;
                                res.send_origin = item.msg_origin;
                                nxt.halted      = 1'b1;
                                res.finished    = 1'b1;
                            end
                        end
                        MK_RESET: begin
                            if (!own) begin
                                nxt.phase       = PH_NORMAL;
                                res.fd_tracking = FD_DISABLE;
                                newgen          = 1'b1;
                                res.send_valid  = 1'b1;
                                res.send_kind   = item.msg_kind;
                                res.send_origin = item.msg_origin;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                OP_IDLE: begin
                    if (!full) begin
                        res.sleep_request = 1'b1;
                    end else begin
                        case (cur.phase)
                            PH_NORMAL: begin
                                nxt.phase       = PH_SHOOT;
                                newgen          = 1'b1;
                                res.send_valid  = 1'b1;
                                res.send_kind   = MK_SHOOT;
                                res.send_origin = node_id;
                            end
                            PH_SHOOT: begin
                                nxt.phase       = PH_WAIT1;
                                res.send_valid  = 1'b1;
                                res.send_kind   = MK_WAIT1;
                                res.send_origin = node_id;
                            end
                            PH_WAIT1, PH_WAIT2: begin
                                res.sleep_request = 1'b1;
                            end
                            PH_DCHECK: begin
                                if (item.fd_map_empty) begin
                                    nxt.phase       = PH_WAIT2;
                                    res.send_valid  = 1'b1;
                                    res.send_kind   = MK_WAIT2;
                                    res.send_origin = node_id;
                                end else begin
                                    nxt.phase        = PH_POLL;
                                    res.eventfd_mode = EFD_START;
                                end
                            end
                            default: begin
                                if (item.poll_ready) begin
                                    res.eventfd_mode = EFD_STOP;
                                    bnorm            = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                end
            endcase
        end

        if (bnorm) begin
            nxt.phase       = PH_NORMAL;
            res.fd_tracking = FD_DISABLE;
            newgen          = 1'b1;
            res.send_valid  = 1'b1;
            res.send_kind   = MK_RESET;
            res.send_origin = node_id;
        end
        if (inc && cur.idle_points < task_count) begin
            nxt.idle_points = cur.idle_points + 1'b1;
        end
        if (newgen) begin
            nxt.gen_count   = cur.gen_count + 1'b1;
            nxt.idle_points = '0;
        end
        res.generation = nxt.gen_count;
        res.node_state = nxt.phase;
    end

endmodule

FILE: rtl/ring_termination_detector_core.sv
// Top level of one ring termination detector node: item registers, node state, config.
//
// One item per cycle while the output is not stalled: an accepted item sits in
// the input register, then the step logic updates the node state and loads the
// result register once that register is free or being read. The node state
// (phase, generation, idle count, halted flag) is the only loop, closed through
// that single step. The input register is refilled in the same cycle its item
// moves on, so one new item can still be taken while a finished result waits
// for m_ready. Configuration writes are always taken (cfg_ready is tied high);
// indexes past the task count register are ignored.
module ring_termination_detector_core import rtd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic [2:0]            s_task_outcome,
    input  logic [2:0]            s_msg_kind,
    input  logic [NODE_W-1:0]     s_msg_origin,
    input  logic                  s_fd_map_empty,
    input  logic                  s_poll_ready,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic                  m_send_valid,
    output logic [2:0]            m_send_kind,
    output logic [NODE_W-1:0]     m_send_origin,
    output logic [1:0]            m_fd_tracking,
    output logic [1:0]            m_eventfd_mode,
    output logic                  m_sleep_request,
    output logic                  m_finished,
    output logic [GEN_WIDTH-1:0]  m_generation,
    output logic [2:0]            m_node_state
);

    logic [NODE_W-1:0] node_id_reg;
    logic [TASK_W-1:0] task_count_reg;
    logic              in_vld_reg;
    item_t             in_item_reg;
    item_t             in_item_next;
    logic              out_vld_reg;
    result_t           out_res_reg;
    result_t           out_res_next;
    node_state_t       state_reg;
    node_state_t       state_next;
    logic              advance;

    assign cfg_ready = 1'b1;
    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;

    assign in_item_next = '{opcode:       s_opcode,
                            task_outcome: s_task_outcome,
                            msg_kind:     s_msg_kind,
                            msg_origin:   s_msg_origin,
                            fd_map_empty: s_fd_map_empty,
                            poll_ready:   s_poll_ready};

    rtd_step u_step (
        .item       (in_item_reg),
        .node_id    (node_id_reg),
        .task_count (task_count_reg),
        .cur        (state_reg),
        .nxt        (state_next),
        .res        (out_res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            node_id_reg    <= '0;
            task_count_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_NODE_ID) begin
                node_id_reg <= cfg_data[NODE_W-1:0];
            end else if (cfg_index == CFG_TASK_COUNT) begin
                task_count_reg <= cfg_data[TASK_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '{phase: PH_NORMAL, gen_count: '0, idle_points: '0, halted: 1'b0};
        end else begin
            if (s_valid && s_ready) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= in_item_next;
        end
        if (advance) begin
            out_res_reg <= out_res_next;
        end
    end

    assign m_valid         = out_vld_reg;
    assign m_send_valid    = out_res_reg.send_valid;
    assign m_send_kind     = out_res_reg.send_kind;
    assign m_send_origin   = out_res_reg.send_origin;
    assign m_fd_tracking   = out_res_reg.fd_tracking;
    assign m_eventfd_mode  = out_res_reg.eventfd_mode;
    assign m_sleep_request = out_res_reg.sleep_request;
    assign m_finished      = out_res_reg.finished;
    assign m_generation    = out_res_reg.generation;
    assign m_node_state    = out_res_reg.node_state;

`ifndef NO_ASSERTIONS
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.halted |=> state_reg.halted)
        else $error("halted flag cleared");

    a_fin_halted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_finished |-> state_reg.halted)
        else $error("finished reported while node not halted");

    a_quiet_send: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_send_valid |-> m_send_kind == '0 && m_send_origin == '0)
        else $error("message fields set without a send");

    a_sleep_nosend: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_sleep_request |-> !m_send_valid && m_fd_tracking == FD_KEEP)
        else $error("sleep request together with an action");

    a_advance_room: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> out_vld_reg && state_reg == $past(state_next))
        else $error("step result not captured");
`endif

endmodule
